### hdl/cau_pkg.sv
`default_nettype none
package cau_pkg;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_MAG = 3'd4,
        CMD_EQ  = 3'd5
    } t_cmd;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } t_in;

    typedef struct packed {
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
        logic               is_equal;
        logic               div_zero;
        logic               overflow;
    } t_out;

    // width of a saturating magnitude: 33 quotient bits plus an overflow-forced top bit
    localparam int QW = 34;

    // sign and magnitude to 32-bit two's complement, top bit of the result is overflow
    function automatic logic [32:0] sat_mag(input logic neg, input logic [QW-1:0] mag);
        logic [32:0] r;
        if (!neg) begin
            if (mag > QW'(32'h7FFF_FFFF)) r = {1'b1, 32'h7FFF_FFFF};
            else r = {1'b0, mag[31:0]};
        end else begin
            if (mag > QW'(32'h8000_0000)) r = {1'b1, 32'h8000_0000};
            else r = {1'b0, 32'd0 - mag[31:0]};
        end
        return r;
    endfunction

    function automatic logic [32:0] sat_s66(input logic signed [65:0] x);
        logic [32:0] r;
        if (x > $signed(66'h0_7FFF_FFFF)) r = {1'b1, 32'h7FFF_FFFF};
        else if (x < -$signed(66'h0_8000_0000)) r = {1'b1, 32'h8000_0000};
        else r = {1'b0, x[31:0]};
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/complex_arithmetic_unit.sv
// channel   direction  handshake            payload
// command   in         start high, busy low i_item (t_in)
// result    out        o_strobe, one cycle  o_res  (t_out)
//
// one word enters per cycle; busy never rises
// every command passes the same stages: product stage, sum stage, divider setup,
// 33 radix-2 restoring divider / square root steps, output register
// the divide and square root pipelines set both the latency and its depth
// synchronous active-low reset clears the valid bits only; the receiver cannot stall
`default_nettype none
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire cau_pkg::t_in i_item,
    output logic              o_strobe,
    output cau_pkg::t_out     o_res
);
    import cau_pkg::*;

    localparam int NS  = 33;              // quotient bits 32..0
    localparam int W   = 98 + FRAC_BITS;  // remainder and shifted divisor width
    localparam int LAT = NS + 4;

    assign busy = 1'b0;

    // stage 1: products, sums or differences, and the equality and zero-divisor flags
    logic               r1_v;
    logic [2:0]         r1_cmd;
    logic signed [63:0] r1_rr, r1_ii, r1_ri, r1_ir, r1_ar2, r1_ai2, r1_br2, r1_bi2;
    logic signed [32:0] r1_sre, r1_sim;
    logic               r1_eq, r1_bz;
    logic signed [32:0] n1_sre, n1_sim;

    always_comb begin
        if (i_item.command == CMD_SUB) begin
            n1_sre = $signed({i_item.a_re[31], i_item.a_re}) - $signed({i_item.b_re[31], i_item.b_re});
            n1_sim = $signed({i_item.a_im[31], i_item.a_im}) - $signed({i_item.b_im[31], i_item.b_im});
        end else begin
            n1_sre = $signed({i_item.a_re[31], i_item.a_re}) + $signed({i_item.b_re[31], i_item.b_re});
            n1_sim = $signed({i_item.a_im[31], i_item.a_im}) + $signed({i_item.b_im[31], i_item.b_im});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else r1_v <= start & ~busy;
        r1_cmd <= i_item.command;
        r1_rr  <= i_item.a_re * i_item.b_re;
        r1_ii  <= i_item.a_im * i_item.b_im;
        r1_ri  <= i_item.a_re * i_item.b_im;
        r1_ir  <= i_item.a_im * i_item.b_re;
        r1_ar2 <= i_item.a_re * i_item.a_re;
        r1_ai2 <= i_item.a_im * i_item.a_im;
        r1_br2 <= i_item.b_re * i_item.b_re;
        r1_bi2 <= i_item.b_im * i_item.b_im;
        r1_sre <= n1_sre;
        r1_sim <= n1_sim;
        r1_eq  <= (i_item.a_re == i_item.b_re) && (i_item.a_im == i_item.b_im);
        r1_bz  <= (i_item.b_re == 32'sd0) && (i_item.b_im == 32'sd0);
    end

    // stage 2: sums, and the final result of the short commands
    logic signed [65:0] n2_mx, n2_my, n2_dx, n2_dy;
    logic [63:0]        n2_d, n2_v;
    logic [32:0]        n2_pre, n2_pim;
    t_out               n2_sp;

    always_comb begin
        n2_mx = 66'(r1_rr) - 66'(r1_ii);
        n2_my = 66'(r1_ri) + 66'(r1_ir);
        n2_dx = 66'(r1_rr) + 66'(r1_ii);
        n2_dy = 66'(r1_ir) - 66'(r1_ri);
        n2_d  = $unsigned(r1_br2) + $unsigned(r1_bi2);
        n2_v  = $unsigned(r1_ar2) + $unsigned(r1_ai2);
        n2_sp = '0;
        case (r1_cmd)
            CMD_ADD, CMD_SUB: begin
                n2_pre = sat_s66(66'(r1_sre));
                n2_pim = sat_s66(66'(r1_sim));
            end
            CMD_MUL: begin
                n2_pre = sat_s66(n2_mx >>> FRAC_BITS);
                n2_pim = sat_s66(n2_my >>> FRAC_BITS);
            end
            default: begin
                n2_pre = '0;
                n2_pim = '0;
            end
        endcase
        n2_sp.res_re   = n2_pre[31:0];
        n2_sp.res_im   = n2_pim[31:0];
        n2_sp.overflow = n2_pre[32] | n2_pim[32];
        n2_sp.is_equal = (r1_cmd == CMD_EQ) && r1_eq;
    end

    logic               r2_v, r2_bz;
    logic [2:0]         r2_cmd;
    logic signed [65:0] r2_dx, r2_dy;
    logic [63:0]        r2_d, r2_v2;
    t_out               r2_sp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else r2_v <= r1_v;
        r2_bz  <= r1_bz;
        r2_cmd <= r1_cmd;
        r2_dx  <= n2_dx;
        r2_dy  <= n2_dy;
        r2_d   <= n2_d;
        r2_v2  <= n2_v;
        r2_sp  <= n2_sp;
    end

    // divider and square root pipeline, index 0 is the setup stage
    logic        r_v   [0:NS];
    logic        r_bz  [0:NS];
    logic [2:0]  r_cmd [0:NS];
    logic [63:0] r_d   [0:NS];
    logic        r_ngr [0:NS];
    logic        r_ngi [0:NS];
    logic        r_bgr [0:NS];
    logic        r_bgi [0:NS];
    t_out        r_sp  [0:NS];
    logic [W-1:0]  r_rr [0:NS];
    logic [W-1:0]  r_ri [0:NS];
    logic [NS-1:0] r_qr [0:NS];
    logic [NS-1:0] r_qi [0:NS];
    logic [65:0]   r_sv [0:NS];
    logic [65:0]   r_sr [0:NS];

    logic [65:0]  n_mre, n_mim;
    logic [W-1:0] n_nre, n_nim, n_dtop;

    always_comb begin
        n_mre  = r2_dx[65] ? 66'(-r2_dx) : r2_dx;
        n_mim  = r2_dy[65] ? 66'(-r2_dy) : r2_dy;
        n_nre  = W'(n_mre) << FRAC_BITS;
        n_nim  = W'(n_mim) << FRAC_BITS;
        n_dtop = W'(r2_d) << NS;
    end

    logic [W-1:0]  n_rr [1:NS];
    logic [W-1:0]  n_ri [1:NS];
    logic [NS-1:0] n_qr [1:NS];
    logic [NS-1:0] n_qi [1:NS];
    logic [65:0]   n_sv [1:NS];
    logic [65:0]   n_sr [1:NS];

    // one quotient bit for each of the real and imaginary parts and one root bit per stage
    always_comb begin
        for (int k = 0; k < NS; k++) begin
            n_rr[k+1] = r_rr[k];
            n_qr[k+1] = r_qr[k];
            if (r_rr[k] >= (W'(r_d[k]) << (NS - 1 - k))) begin
                n_rr[k+1] = r_rr[k] - (W'(r_d[k]) << (NS - 1 - k));
                n_qr[k+1][NS-1-k] = 1'b1;
            end
            n_ri[k+1] = r_ri[k];
            n_qi[k+1] = r_qi[k];
            if (r_ri[k] >= (W'(r_d[k]) << (NS - 1 - k))) begin
                n_ri[k+1] = r_ri[k] - (W'(r_d[k]) << (NS - 1 - k));
                n_qi[k+1][NS-1-k] = 1'b1;
            end
            if (r_sv[k] >= r_sr[k] + (66'd1 << (2 * (NS - 1 - k)))) begin
                n_sv[k+1] = r_sv[k] - (r_sr[k] + (66'd1 << (2 * (NS - 1 - k))));
                n_sr[k+1] = (r_sr[k] >> 1) + (66'd1 << (2 * (NS - 1 - k)));
            end else begin
                n_sv[k+1] = r_sv[k];
                n_sr[k+1] = r_sr[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NS; k++) r_v[k] <= 1'b0;
        end else begin
            r_v[0] <= r2_v;
            for (int k = 0; k < NS; k++) r_v[k+1] <= r_v[k];
        end
        r_bz[0]  <= r2_bz;
        r_cmd[0] <= r2_cmd;
        r_d[0]   <= r2_d;
        r_ngr[0] <= r2_dx[65];
        r_ngi[0] <= r2_dy[65];
        // a quotient of 2^33 or more only saturates
        r_bgr[0] <= n_nre >= n_dtop;
        r_bgi[0] <= n_nim >= n_dtop;
        r_sp[0]  <= r2_sp;
        r_rr[0]  <= n_nre;
        r_ri[0]  <= n_nim;
        r_qr[0]  <= '0;
        r_qi[0]  <= '0;
        r_sv[0]  <= {2'b00, r2_v2};
        r_sr[0]  <= '0;
        for (int k = 0; k < NS; k++) begin
            r_bz[k+1]  <= r_bz[k];
            r_cmd[k+1] <= r_cmd[k];
            r_d[k+1]   <= r_d[k];
            r_ngr[k+1] <= r_ngr[k];
            r_ngi[k+1] <= r_ngi[k];
            r_bgr[k+1] <= r_bgr[k];
            r_bgi[k+1] <= r_bgi[k];
            r_sp[k+1]  <= r_sp[k];
            r_rr[k+1]  <= n_rr[k+1];
            r_ri[k+1]  <= n_ri[k+1];
            r_qr[k+1]  <= n_qr[k+1];
            r_qi[k+1]  <= n_qi[k+1];
            r_sv[k+1]  <= n_sv[k+1];
            r_sr[k+1]  <= n_sr[k+1];
        end
    end

    // output select and saturation
    logic [32:0] n_fre, n_fim, n_fmg;
    t_out        n_res;

    always_comb begin
        n_fre = sat_mag(r_ngr[NS], r_bgr[NS] ? '1 : {1'b0, r_qr[NS]});
        n_fim = sat_mag(r_ngi[NS], r_bgi[NS] ? '1 : {1'b0, r_qi[NS]});
        n_fmg = sat_mag(1'b0, r_sr[NS][QW-1:0]);
        n_res = '0;
        case (r_cmd[NS])
            CMD_DIV: begin
                if (r_bz[NS]) begin
                    n_res.div_zero = 1'b1;
                end else begin
                    n_res.res_re   = n_fre[31:0];
                    n_res.res_im   = n_fim[31:0];
                    n_res.overflow = n_fre[32] | n_fim[32];
                end
            end
            CMD_MAG: begin
                n_res.res_re   = n_fmg[31:0];
                n_res.overflow = n_fmg[32];
            end
            default: n_res = r_sp[NS];
        endcase
    end

    t_out r_res;
    logic r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_strobe <= 1'b0;
        else r_strobe <= r_v[NS];
        r_res <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_strobe)
        else $error("word lost in pipeline");

    a_divzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.div_zero) |->
            (o_res.res_re == 32'sd0 && o_res.res_im == 32'sd0 && !o_res.overflow))
        else $error("zero divisor gave nonzero result");

    a_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.is_equal) |->
            (o_res.res_re == 32'sd0 && o_res.res_im == 32'sd0 && !o_res.div_zero
             && !o_res.overflow))
        else $error("equality result carries other fields");

endmodule
`default_nettype wire

### sim/cau_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module cau_checker #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic          busy,
    input  wire cau_pkg::t_in  i_item,
    input  wire logic          o_strobe,
    input  wire cau_pkg::t_out o_res,
    output int                 o_pending,
    output int                 o_errors
);
    import cau_pkg::*;

    t_out expected_results[$];

    // saturate to 32 bits, top bit flags the clamp
    function automatic logic [32:0] clamp32(input logic signed [127:0] v);
        logic [32:0] r;
        if (v > 128'sh7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
        else if (v < -128'sh8000_0000) r = {1'b1, 32'h8000_0000};
        else r = {1'b0, v[31:0]};
        return r;
    endfunction

    // quotient of (n << FRAC_BITS) / d, truncated toward zero
    function automatic logic signed [127:0] frac_quot(input logic signed [127:0] n,
                                                      input logic signed [127:0] d);
        logic signed [127:0] m;
        logic signed [127:0] q;
        m = (n < 0) ? -n : n;
        q = (m <<< FRAC_BITS) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_out predict_result(input t_in w);
        t_out r;
        logic signed [127:0] ar, ai, br, bi, d;
        logic [32:0] pr, pi;
        ar = 128'(w.a_re);
        ai = 128'(w.a_im);
        br = 128'(w.b_re);
        bi = 128'(w.b_im);
        r = '0;
        pr = '0;
        pi = '0;
        case (w.command)
            CMD_ADD: begin
                pr = clamp32(ar + br);
                pi = clamp32(ai + bi);
            end
            CMD_SUB: begin
                pr = clamp32(ar - br);
                pi = clamp32(ai - bi);
            end
            CMD_MUL: begin
                pr = clamp32((ar * br - ai * bi) >>> FRAC_BITS);
                pi = clamp32((ar * bi + ai * br) >>> FRAC_BITS);
            end
            CMD_DIV: begin
                if (br == 0 && bi == 0) begin
                    r.div_zero = 1'b1;
                end else begin
                    d = br * br + bi * bi;
                    pr = clamp32(frac_quot(ar * br + ai * bi, d));
                    pi = clamp32(frac_quot(ai * br - ar * bi, d));
                end
            end
            CMD_MAG: begin
                pr = clamp32($signed({64'd0, floor_sqrt(64'(ar * ar + ai * ai))}));
            end
            CMD_EQ: begin
                r.is_equal = (ar == br) && (ai == bi);
            end
            default: ;
        endcase
        r.res_re = pr[31:0];
        r.res_im = pi[31:0];
        r.overflow = pr[32] | pi[32];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out e;
        if (!i_rst_n) begin
            expected_results.delete();
            o_errors <= 0;
        end else begin
            if (start && !busy) expected_results.push_back(predict_result(i_item));
            if (o_strobe) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, o_res);
                    o_errors <= o_errors + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (e.res_re !== o_res.res_re || e.res_im !== o_res.res_im
                        || e.is_equal !== o_res.is_equal || e.div_zero !== o_res.div_zero
                        || e.overflow !== o_res.overflow) begin
                        $display("%0t: mismatch expected re=%h im=%h eq=%b dz=%b ovf=%b",
                                 $time, e.res_re, e.res_im, e.is_equal, e.div_zero,
                                 e.overflow);
                        $display("%0t:          actual   re=%h im=%h eq=%b dz=%b ovf=%b",
                                 $time, o_res.res_re, o_res.res_im, o_res.is_equal,
                                 o_res.div_zero, o_res.overflow);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= expected_results.size();
    end
endmodule
`default_nettype wire

### sim/tb_complex_arithmetic_unit.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_complex_arithmetic_unit;
    import cau_pkg::*;

    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;
    localparam int N_RANDOM = 1930;
    localparam int CYCLE_LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in  i_item = '0;
    logic o_strobe;
    t_out o_res;
    int   n_pending;
    int   n_errors;
    int   cycles = 0;
    int   burst_left = 0;

    always #5 i_clk = ~i_clk;

    complex_arithmetic_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_strobe(o_strobe), .o_res(o_res)
    );

    cau_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_strobe(o_strobe), .o_res(o_res),
        .o_pending(n_pending), .o_errors(n_errors)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 64)) - 32);
            default: return $urandom();
        endcase
    endfunction

    // hold start across a burst, and between bursts sometimes drop it for a random gap
    task automatic send_word(input logic [2:0] cmd, input logic [31:0] ar,
                             input logic [31:0] ai, input logic [31:0] br,
                             input logic [31:0] bi);
        logic taken;
        int   gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        start <= 1'b1;
        i_item <= '{command: cmd, a_re: ar, a_im: ai, b_re: br, b_im: bi};
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
    endtask

    initial begin
        logic [2:0] cmd;
        logic [31:0] ar, ai, br, bi;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
        send_word(CMD_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(CMD_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        send_word(CMD_SUB, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000);
        send_word(CMD_MUL, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000);
        send_word(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_word(CMD_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'h0000_0003);
        send_word(CMD_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(CMD_DIV, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_word(CMD_DIV, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_word(CMD_DIV, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'hFFFF_0000);
        send_word(CMD_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
        send_word(CMD_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_word(CMD_DIV, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(CMD_MAG, 32'h8000_0000, 32'h8000_0000, 32'h1234_5678, 32'h0);
        send_word(CMD_MAG, 32'h0003_0000, 32'hFFFC_0000, 32'h0, 32'h0);
        send_word(CMD_MAG, 32'h0000_0000, 32'h0000_0000, 32'h0, 32'h0);
        send_word(CMD_EQ, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(CMD_EQ, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFE);
        send_word(CMD_EQ, 32'h0000_0001, 32'h0, 32'h0, 32'h0);
        send_word(CMD_RSVD6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_RSVD7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);

        for (int n = 0; n < N_RANDOM; n++) begin
            cmd = ($urandom_range(0, 31) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
            ar = rand_operand();
            ai = rand_operand();
            br = rand_operand();
            bi = rand_operand();
            if (cmd == CMD_EQ && $urandom_range(0, 1)) begin
                br = ar;
                bi = $urandom_range(0, 1) ? ai : ai ^ (32'd1 << $urandom_range(0, 31));
            end
            if (cmd == CMD_DIV && $urandom_range(0, 9) == 0) begin
                br = 0;
                bi = $urandom_range(0, 1) ? 32'd0 : bi;
            end
            send_word(cmd, ar, ai, br, bi);
        end
        start <= 1'b0;

        while (n_pending != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
        if (n_errors == 0 && n_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
